// ----- sv/tbr_pkg.sv -----
// Shared types and constants for the triangle bounding-box rasterizer.
package tbr_pkg;

  localparam int IN_CW     = 12;  // width of a vertex coordinate field
  localparam int DIM_W     = 11;  // width of image sizes and box bounds
  localparam int PIX_W     = 10;  // width of a reported pixel coordinate
  localparam int SHADE_W   = 8;
  localparam int CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'b1;

  localparam logic MODE_LOAD = 1'b0;
  localparam logic MODE_TICK = 1'b1;

  localparam logic [DIM_W-1:0] RESET_DIM = 11'd800;

  typedef struct packed {
    logic                     mode;
    logic signed [IN_CW-1:0]  ax;
    logic signed [IN_CW-1:0]  ay;
    logic signed [IN_CW-1:0]  bx;
    logic signed [IN_CW-1:0]  by_coord;
    logic signed [IN_CW-1:0]  cx;
    logic signed [IN_CW-1:0]  cy;
    logic        [SHADE_W-1:0] shade;
  } tbr_in_t;

  typedef struct packed {
    logic [PIX_W-1:0]   pixel_x;
    logic [PIX_W-1:0]   pixel_y;
    logic               covered;
    logic [SHADE_W-1:0] pixel_shade;
    logic               done_res;
  } tbr_out_t;

endpackage

// ----- sv/tbr_mul.sv -----
// Shared signed multiplier with a registered product.
module tbr_mul #(
  parameter int OW = 13
) (
  input  logic                   clk,
  input  logic signed [OW-1:0]   op_a,
  input  logic signed [OW-1:0]   op_b,
  output logic signed [2*OW-1:0] prod
);

  always_ff @(posedge clk) begin
    prod <= op_a * op_b;
  end

endmodule

// ----- sv/triangle_bbox_rasterizer.sv -----
// Top level of the triangle bounding-box rasterizer.
// A load transaction keeps in_ready low through S_AREA0, S_AREA1 and S_AREA2 while the
// shared multiplier forms the two products of the doubled area.
// A tick with a triangle loaded steps through the multiplier states S_MUL0 to S_MUL3 and
// then S_EVAL, which sums and tests signs; its result is registered from S_EVAL.
// A tick with no triangle loaded returns its result in the next cycle. rst_n is synchronous
// and active low; it clears the sequencer, output register and loaded flag, sizes to 800.
module triangle_bbox_rasterizer
  import tbr_pkg::*;
#(
  parameter int MAX_IMAGE_SIZE = 1024,
  parameter int COORD_BITS     = 12
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  tbr_in_t              in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output tbr_out_t             out_data,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DIM_W-1:0]     cfg_wdata
);

  localparam int OW  = ((COORD_BITS > IN_CW) ? COORD_BITS : IN_CW) + 1;
  localparam int PW  = 2 * OW;
  localparam int AW  = PW + 3;
  localparam int SHL = (COORD_BITS < IN_CW) ? IN_CW - COORD_BITS : 0;
  localparam logic [DIM_W+1:0] MAX_DIM = (DIM_W + 2)'(MAX_IMAGE_SIZE);

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_AREA0 = 9'b000000010,
    S_AREA1 = 9'b000000100,
    S_AREA2 = 9'b000001000,
    S_MUL0  = 9'b000010000,
    S_MUL1  = 9'b000100000,
    S_MUL2  = 9'b001000000,
    S_MUL3  = 9'b010000000,
    S_EVAL  = 9'b100000000
  } state_t;

  function automatic logic signed [OW-1:0] sx(input logic [IN_CW-1:0] raw);
    logic signed [IN_CW-1:0] t;
    t = signed'(raw << SHL);
    t = t >>> SHL;
    if (COORD_BITS <= IN_CW) begin
      sx = OW'(t);
    end else begin
      sx = signed'(OW'(raw));
    end
  endfunction

  function automatic logic [DIM_W-1:0] clampd(input logic signed [OW-1:0] v,
                                              input logic [DIM_W-1:0] hi);
    if (v < 0) begin
      clampd = '0;
    end else if (v > signed'(OW'(hi))) begin
      clampd = hi;
    end else begin
      clampd = DIM_W'(v);
    end
  endfunction

  function automatic logic signed [OW-1:0] min3(input logic signed [OW-1:0] a,
                                               input logic signed [OW-1:0] b,
                                               input logic signed [OW-1:0] c);
    logic signed [OW-1:0] m;
    m = (a < b) ? a : b;
    min3 = (m < c) ? m : c;
  endfunction

  function automatic logic signed [OW-1:0] max3(input logic signed [OW-1:0] a,
                                               input logic signed [OW-1:0] b,
                                               input logic signed [OW-1:0] c);
    logic signed [OW-1:0] m;
    m = (a > b) ? a : b;
    max3 = (m > c) ? m : c;
  endfunction

  state_t state_r, state_nxt;

  logic [DIM_W-1:0] img_w_r, img_h_r;
  logic [DIM_W-1:0] cfg_val;

  logic signed [OW-1:0] ax_r, ay_r, abx_r, aby_r, acx_r, acy_r, pax_r, pay_r;
  logic [DIM_W-1:0]     min_x_r, min_y_r, max_x_r, max_y_r, scan_x_r, scan_y_r;
  logic signed [AW-1:0] area_r, u_r, v_r;
  logic [SHADE_W-1:0]   shade_r;
  logic                 active_r;
  logic                 out_valid_r;
  tbr_out_t             out_data_r;

  logic                 in_fire;
  logic signed [OW-1:0] vax, vay, vbx, vby, vcx, vcy;
  logic [DIM_W-1:0]     wmax, hmax;

  logic signed [OW-1:0] mul_a, mul_b;
  logic signed [PW-1:0] prod;
  logic signed [AW-1:0] prod_x, w_val;
  logic                 area_pos, covered, last_px;

  assign in_ready  = (state_r == S_IDLE) && (!out_valid_r || out_ready);
  assign in_fire   = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Configuration: a zero size counts as one, an oversize one as the maximum.
  always_comb begin
    if (cfg_wdata == '0) begin
      cfg_val = DIM_W'(1);
    end else if ({2'b00, cfg_wdata} > MAX_DIM) begin
      cfg_val = DIM_W'(MAX_IMAGE_SIZE);
    end else begin
      cfg_val = cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      img_w_r <= RESET_DIM;
      img_h_r <= RESET_DIM;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_IMAGE_WIDTH:  img_w_r <= cfg_val;
        REG_IMAGE_HEIGHT: img_h_r <= cfg_val;
        default: ;
      endcase
    end
  end

  assign vax  = sx(in_data.ax);
  assign vay  = sx(in_data.ay);
  assign vbx  = sx(in_data.bx);
  assign vby  = sx(in_data.by_coord);
  assign vcx  = sx(in_data.cx);
  assign vcy  = sx(in_data.cy);
  assign wmax = img_w_r - DIM_W'(1);
  assign hmax = img_h_r - DIM_W'(1);

  // Operand selection for the shared multiplier.
  always_comb begin
    case (state_r)
      S_AREA0: begin mul_a = abx_r; mul_b = acy_r; end
      S_AREA1: begin mul_a = acx_r; mul_b = aby_r; end
      S_MUL0:  begin mul_a = acx_r; mul_b = pay_r; end
      S_MUL1:  begin mul_a = pax_r; mul_b = acy_r; end
      S_MUL2:  begin mul_a = pax_r; mul_b = aby_r; end
      S_MUL3:  begin mul_a = abx_r; mul_b = pay_r; end
      default: begin mul_a = '0;    mul_b = '0;    end
    endcase
  end

  tbr_mul #(.OW(OW)) u_mul (
    .clk  (clk),
    .op_a (mul_a),
    .op_b (mul_b),
    .prod (prod)
  );

  assign prod_x = {{(AW - PW){prod[PW-1]}}, prod};

  // The multiplier registers each product, so u and v are assembled in the state
  // after the one that sets its operands, and finished in S_EVAL.
  assign w_val    = area_r - u_r - (v_r - prod_x);
  assign area_pos = !area_r[AW-1];
  always_comb begin
    if (area_r == '0) begin
      covered = 1'b0;
    end else if (area_pos) begin
      covered = !u_r[AW-1] && !(v_r - prod_x < 0) && !w_val[AW-1];
    end else begin
      covered = (u_r <= 0) && (v_r - prod_x <= 0) && (w_val <= 0);
    end
  end
  assign last_px = (scan_x_r == max_x_r) && (scan_y_r == max_y_r);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          if (in_data.mode == MODE_LOAD) begin
            state_nxt = S_AREA0;
          end else if (active_r) begin
            state_nxt = S_MUL0;
          end
        end
      end
      S_AREA0: state_nxt = S_AREA1;
      S_AREA1: state_nxt = S_AREA2;
      S_AREA2: state_nxt = S_IDLE;
      S_MUL0:  state_nxt = S_MUL1;
      S_MUL1:  state_nxt = S_MUL2;
      S_MUL2:  state_nxt = S_MUL3;
      S_MUL3:  state_nxt = S_EVAL;
      S_EVAL:  state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Triangle setup, scan position and edge accumulation.
  always_ff @(posedge clk) begin
    if (in_fire && (state_r == S_IDLE)) begin
      if (in_data.mode == MODE_LOAD) begin
        ax_r     <= vax;
        ay_r     <= vay;
        abx_r    <= vbx - vax;
        aby_r    <= vby - vay;
        acx_r    <= vcx - vax;
        acy_r    <= vcy - vay;
        min_x_r  <= clampd(min3(vax, vbx, vcx), wmax);
        min_y_r  <= clampd(min3(vay, vby, vcy), hmax);
        max_x_r  <= clampd(max3(vax, vbx, vcx), wmax);
        max_y_r  <= clampd(max3(vay, vby, vcy), hmax);
        scan_x_r <= clampd(min3(vax, vbx, vcx), wmax);
        scan_y_r <= clampd(min3(vay, vby, vcy), hmax);
        shade_r  <= in_data.shade;
      end else begin
        pax_r <= ax_r - signed'(OW'(scan_x_r));
        pay_r <= ay_r - signed'(OW'(scan_y_r));
      end
    end
    case (state_r)
      S_AREA1: area_r <= prod_x;
      S_AREA2: area_r <= area_r - prod_x;
      S_MUL1:  u_r    <= prod_x;
      S_MUL2:  u_r    <= u_r - prod_x;
      S_MUL3:  v_r    <= prod_x;
      S_EVAL: begin
        if (!last_px) begin
          if (scan_y_r < max_y_r) begin
            scan_y_r <= scan_y_r + DIM_W'(1);
          end else begin
            scan_y_r <= min_y_r;
            scan_x_r <= scan_x_r + DIM_W'(1);
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
    end else if (in_fire && (in_data.mode == MODE_LOAD)) begin
      active_r <= 1'b1;
    end else if ((state_r == S_EVAL) && last_px) begin
      active_r <= 1'b0;
    end
  end

  // Output register: an idle tick is answered from S_IDLE, a scanned pixel from S_EVAL.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_fire && (in_data.mode == MODE_TICK) && !active_r) begin
      out_valid_r <= 1'b1;
    end else if (state_r == S_EVAL) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && (in_data.mode == MODE_TICK) && !active_r) begin
      out_data_r <= '{pixel_x: '0, pixel_y: '0, covered: 1'b0,
                      pixel_shade: '0, done_res: 1'b1};
    end else if (state_r == S_EVAL) begin
      out_data_r <= '{pixel_x: scan_x_r[PIX_W-1:0], pixel_y: scan_y_r[PIX_W-1:0],
                      covered: covered, pixel_shade: shade_r, done_res: last_px};
    end
  end

endmodule

// ----- sv/tbr_checker.sv -----
// Port-level checks for the triangle bounding-box rasterizer, bound to the top level.
module tbr_checker
  import tbr_pkg::*;
(
  input logic     clk,
  input logic     rst_n,
  input logic     in_valid,
  input logic     in_ready,
  input tbr_in_t  in_data,
  input logic     out_valid,
  input logic     out_ready,
  input tbr_out_t out_data
);

  // A result that is not taken holds its value.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // No new transaction is taken while a result waits on a stalled output.
  a_no_accept_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |-> !in_ready)
    else $error("input accepted while the output is stalled");

  // Setting up a triangle occupies the block for the following cycles.
  a_load_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_data.mode == MODE_LOAD) |=> !in_ready ##1 !in_ready)
    else $error("input accepted during triangle setup");

  // Reset empties the output register.
  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid after reset");

endmodule

bind triangle_bbox_rasterizer tbr_checker u_tbr_checker (.*);

// ----- tb/tb.sv -----
// Self-checking testbench for the triangle bounding-box rasterizer.
`timescale 1ns / 100ps

module tb;
  import tbr_pkg::*;

  localparam int    IMG_MAX     = 1024;
  localparam int    LOAD_SETTLE = 12;      // cycles for a trailing load to finish
  localparam int    END_DRAIN   = 20;
  localparam int    LONG_HOLD   = 300;
  localparam longint CYCLE_LIMIT = 400000;

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_ready;
  tbr_in_t              in_data;
  logic                 out_valid;
  logic                 out_ready;
  tbr_out_t             out_data;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [DIM_W-1:0]     cfg_wdata;

  triangle_bbox_rasterizer dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  typedef struct packed {
    tbr_in_t  stim;
    logic     typed;
    tbr_out_t res;
  } dir_row_t;

  // Rasterizer state as the block should hold it.
  longint   img_w, img_h;
  longint   tri_v [6];
  longint   box_x0, box_y0, box_x1, box_y1;
  longint   scan_px, scan_py;
  longint   tri_area2;
  logic [SHADE_W-1:0] tri_shade;
  bit       scanning;

  tbr_out_t pixel_q [$];
  dir_row_t dir_rows [$];
  int       errors;
  int       items_sent;
  int       send_idle_pct;
  int       stall_pct;
  bit       hold_req;
  longint   cycles;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Result side: random back-pressure plus one long hold on request.
  initial begin : rx_ready
    int hold_left;
    hold_left = 0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  task automatic show_diff(string field, longint unsigned want, longint unsigned got);
    $display("%0t: %s expected %0d, got %0d", $time, field, want, got);
    errors++;
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pixel_q.size() == 0) begin
        $display("%0t: unexpected pixel result, expected none, got x %0d y %0d done %0b",
                 $time, out_data.pixel_x, out_data.pixel_y, out_data.done_res);
        errors++;
      end else begin
        tbr_out_t want;
        want = pixel_q.pop_front();
        if (out_data.pixel_x !== want.pixel_x)
          show_diff("pixel_x", want.pixel_x, out_data.pixel_x);
        if (out_data.pixel_y !== want.pixel_y)
          show_diff("pixel_y", want.pixel_y, out_data.pixel_y);
        if (out_data.covered !== want.covered)
          show_diff("covered", want.covered, out_data.covered);
        if (out_data.pixel_shade !== want.pixel_shade)
          show_diff("pixel_shade", want.pixel_shade, out_data.pixel_shade);
        if (out_data.done_res !== want.done_res)
          show_diff("done_res", want.done_res, out_data.done_res);
      end
    end
  end

  function automatic longint dim_value(logic [DIM_W-1:0] raw);
    if (raw == 0) return 1;
    if (raw > IMG_MAX) return IMG_MAX;
    return longint'(raw);
  endfunction

  function automatic longint clamp_to(longint v, longint hi);
    return (v < 0) ? 0 : ((v > hi) ? hi : v);
  endfunction

  function automatic longint lo3(longint a, longint b, longint c);
    longint m;
    m = (a < b) ? a : b;
    return (m < c) ? m : c;
  endfunction

  function automatic longint hi3(longint a, longint b, longint c);
    longint m;
    m = (a > b) ? a : b;
    return (m > c) ? m : c;
  endfunction

  // Edge-sign test against the loaded triangle; edges count as inside.
  function automatic bit pixel_hit(longint px, longint py);
    longint abx, aby, acx, acy, pax, pay, u, v, w;
    abx = tri_v[2] - tri_v[0];
    aby = tri_v[3] - tri_v[1];
    acx = tri_v[4] - tri_v[0];
    acy = tri_v[5] - tri_v[1];
    pax = tri_v[0] - px;
    pay = tri_v[1] - py;
    u = acx * pay - pax * acy;
    v = pax * aby - abx * pay;
    w = tri_area2 - u - v;
    if (tri_area2 == 0) return 1'b0;
    if (tri_area2 < 0) begin
      u = -u;
      v = -v;
      w = -w;
    end
    return (u >= 0) && (v >= 0) && (w >= 0);
  endfunction

  function automatic void rasterize_item(input tbr_in_t it, output bit has_res,
                                         output tbr_out_t res);
    bit last;
    has_res = 1'b0;
    res     = '0;
    if (it.mode == MODE_LOAD) begin
      tri_v[0] = $signed(it.ax);
      tri_v[1] = $signed(it.ay);
      tri_v[2] = $signed(it.bx);
      tri_v[3] = $signed(it.by_coord);
      tri_v[4] = $signed(it.cx);
      tri_v[5] = $signed(it.cy);
      box_x0 = clamp_to(lo3(tri_v[0], tri_v[2], tri_v[4]), img_w - 1);
      box_y0 = clamp_to(lo3(tri_v[1], tri_v[3], tri_v[5]), img_h - 1);
      box_x1 = clamp_to(hi3(tri_v[0], tri_v[2], tri_v[4]), img_w - 1);
      box_y1 = clamp_to(hi3(tri_v[1], tri_v[3], tri_v[5]), img_h - 1);
      tri_area2 = (tri_v[2] - tri_v[0]) * (tri_v[5] - tri_v[1])
                - (tri_v[4] - tri_v[0]) * (tri_v[3] - tri_v[1]);
      tri_shade = it.shade;
      scan_px   = box_x0;
      scan_py   = box_y0;
      scanning  = 1'b1;
      return;
    end
    has_res = 1'b1;
    if (!scanning) begin
      res.done_res = 1'b1;
      return;
    end
    last = (scan_px == box_x1) && (scan_py == box_y1);
    res.pixel_x     = scan_px[PIX_W-1:0];
    res.pixel_y     = scan_py[PIX_W-1:0];
    res.covered     = pixel_hit(scan_px, scan_py);
    res.pixel_shade = tri_shade;
    res.done_res    = last;
    if (last) begin
      scanning = 1'b0;
    end else if (scan_py < box_y1) begin
      scan_py++;
    end else begin
      scan_py = box_y0;
      scan_px++;
    end
  endfunction

  function automatic tbr_in_t mk_load(int ax, int ay, int bx, int by, int cx, int cy,
                                      int shade);
    tbr_in_t t;
    t.mode     = MODE_LOAD;
    t.ax       = ax[IN_CW-1:0];
    t.ay       = ay[IN_CW-1:0];
    t.bx       = bx[IN_CW-1:0];
    t.by_coord = by[IN_CW-1:0];
    t.cx       = cx[IN_CW-1:0];
    t.cy       = cy[IN_CW-1:0];
    t.shade    = shade[SHADE_W-1:0];
    return t;
  endfunction

  function automatic tbr_in_t random_item(logic mode);
    logic [95:0] raw;
    tbr_in_t     t;
    raw    = {$urandom(), $urandom(), $urandom()};
    t      = raw[$bits(tbr_in_t)-1:0];
    t.mode = mode;
    return t;
  endfunction

  function automatic tbr_out_t mk_res(int x, int y, bit cov, int shade, bit done);
    tbr_out_t r;
    r.pixel_x     = x[PIX_W-1:0];
    r.pixel_y     = y[PIX_W-1:0];
    r.covered     = cov;
    r.pixel_shade = shade[SHADE_W-1:0];
    r.done_res    = done;
    return r;
  endfunction

  function automatic void add_row(tbr_in_t stim, bit typed, tbr_out_t res);
    dir_row_t r;
    r.stim  = stim;
    r.typed = typed;
    r.res   = res;
    dir_rows.push_back(r);
  endfunction

  // Entered and left at a falling edge. A typed expectation replaces the
  // predicted one, but the predicted state still advances.
  task automatic send(tbr_in_t it, bit typed, tbr_out_t want);
    bit       has_res;
    tbr_out_t pred;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (!in_ready);
    rasterize_item(it, has_res, pred);
    if (has_res) pixel_q.push_back(typed ? want : pred);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (pixel_q.size() != 0) @(negedge clk);
    repeat (LOAD_SETTLE) @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [DIM_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_IMAGE_WIDTH) img_w = dim_value(value);
    else img_h = dim_value(value);
    @(negedge clk);
  endtask

  // One random sequence: mostly a small triangle scanned to the end.
  task automatic random_sequence();
    int     pick, ox, oy, span;
    longint n;
    pick = $urandom_range(99);
    if (pick < 12) begin
      send(random_item(MODE_LOAD), 1'b0, '0);
      n = $urandom_range(0, 4);
    end else if (pick < 17) begin
      n = $urandom_range(1, 3);
    end else begin
      ox   = int'($urandom_range(0, img_w + 5)) - 3;
      oy   = int'($urandom_range(0, img_h + 5)) - 3;
      span = ($urandom_range(9) == 0) ? 8 : 4;
      send(mk_load(ox + int'($urandom_range(0, span)), oy + int'($urandom_range(0, span)),
                   ox + int'($urandom_range(0, span)), oy + int'($urandom_range(0, span)),
                   ox + int'($urandom_range(0, span)), oy + int'($urandom_range(0, span)),
                   $urandom_range(0, 255)), 1'b0, '0);
      n = (box_x1 - box_x0 + 1) * (box_y1 - box_y0 + 1);
      if ($urandom_range(9) == 0) n = $urandom_range(0, n - 1);
      else n += $urandom_range(0, 2);
    end
    repeat (n) send(random_item(MODE_TICK), 1'b0, '0);
  endtask

  task automatic run_phase(logic [DIM_W-1:0] w, logic [DIM_W-1:0] h, int sidle, int stall,
                           int count, bit long_hold, bit mid_pause);
    int  stop_at;
    bit  paused;
    settle();
    write_reg(REG_IMAGE_WIDTH, w);
    write_reg(REG_IMAGE_HEIGHT, h);
    send_idle_pct = sidle;
    stall_pct     = stall;
    stop_at       = items_sent + count;
    paused        = 1'b0;
    if (long_hold) hold_req = 1'b1;
    while (items_sent < stop_at) begin
      random_sequence();
      // Let the block drain completely once before carrying on.
      if (mid_pause && !paused && items_sent > stop_at - count / 2) begin
        paused = 1'b1;
        settle();
      end
    end
  endtask

  initial begin
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_data       = '0;
    cfg_we        = 1'b0;
    cfg_index     = REG_IMAGE_WIDTH;
    cfg_wdata     = '0;
    cycles        = 0;
    errors        = 0;
    items_sent    = 0;
    send_idle_pct = 0;
    stall_pct     = 0;
    hold_req      = 1'b0;
    img_w         = RESET_DIM;
    img_h         = RESET_DIM;
    foreach (tri_v[i]) tri_v[i] = 0;
    box_x0 = 0; box_y0 = 0; box_x1 = 0; box_y1 = 0;
    scan_px = 0; scan_py = 0; tri_area2 = 0; tri_shade = '0; scanning = 1'b0;

    // Tick with nothing loaded, then a small triangle scanned to its end.
    add_row(random_item(MODE_TICK), 1'b1, mk_res(0, 0, 1'b0, 0, 1'b1));
    add_row(mk_load(0, 0, 1, 0, 0, 1, 255), 1'b0, '0);
    repeat (4) add_row(random_item(MODE_TICK), 1'b0, '0);
    add_row(random_item(MODE_TICK), 1'b1, mk_res(0, 0, 1'b0, 0, 1'b1));
    // Zero-area triangle: a one-pixel box that is never covered.
    add_row(mk_load(5, 5, 5, 5, 5, 5, 0), 1'b0, '0);
    add_row(random_item(MODE_TICK), 1'b1, mk_res(5, 5, 1'b0, 0, 1'b1));
    // Coordinate extremes clamp onto the image corners.
    add_row(mk_load(-2048, -2048, -2048, -2048, -2048, -2048, 255), 1'b0, '0);
    add_row(random_item(MODE_TICK), 1'b1, mk_res(0, 0, 1'b0, 255, 1'b1));
    add_row(mk_load(2047, 2047, 2047, 2047, 2047, 2047, 128), 1'b0, '0);
    add_row(random_item(MODE_TICK), 1'b1, mk_res(799, 799, 1'b0, 128, 1'b1));
    // Real triangle entirely off the image.
    add_row(mk_load(-2048, -2048, -2000, -2048, -2048, -2000, 60), 1'b0, '0);
    add_row(random_item(MODE_TICK), 1'b1, mk_res(0, 0, 1'b0, 60, 1'b1));
    // Full-range triangle, abandoned by a load mid-scan.
    add_row(mk_load(-2048, -2048, 2047, -2048, -2048, 2047, 17), 1'b0, '0);
    repeat (2) add_row(random_item(MODE_TICK), 1'b0, '0);
    // Clockwise winding gives a negative area.
    add_row(mk_load(3, 3, 3, 4, 4, 3, 170), 1'b0, '0);
    repeat (4) add_row(random_item(MODE_TICK), 1'b0, '0);
    add_row(random_item(MODE_TICK), 1'b1, mk_res(0, 0, 1'b0, 0, 1'b1));

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    foreach (dir_rows[i]) send(dir_rows[i].stim, dir_rows[i].typed, dir_rows[i].res);

    run_phase(11'd1,    11'd1,    0,  0,  170, 1'b0, 1'b0);
    run_phase(11'd1024, 11'd1024, 67, 0,  220, 1'b0, 1'b0);
    run_phase(11'd0,    11'd2047, 0,  67, 220, 1'b1, 1'b0);
    run_phase(11'd37,   11'd16,   38, 38, 220, 1'b0, 1'b0);
    run_phase(DIM_W'($urandom_range(1, IMG_MAX)), DIM_W'($urandom_range(1, IMG_MAX)),
              0, 0, 200, 1'b0, 1'b1);
    run_phase(11'd1024, 11'd1,    38, 38, 170, 1'b0, 1'b0);

    in_valid <= 1'b0;
    while (pixel_q.size() != 0) @(posedge clk);
    repeat (END_DRAIN) @(posedge clk);
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
sv/tbr_pkg.sv
sv/tbr_mul.sv
sv/triangle_bbox_rasterizer.sv
sv/tbr_checker.sv
tb/tb.sv
